FILE: rtl/tpds_pkg.sv
// ----------------------------------------------------------------------------
// Timed pump dose sequencer package
// Types, codes and record layouts shared by the sequencer modules.
// ----------------------------------------------------------------------------
package tpds_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned TagW  = 16;
  localparam int unsigned DoseW = 20;

  localparam logic [DoseW-1:0] MaxDoseReset = DoseW'(30000);

  typedef enum logic [2:0] {
    OP_BEGIN   = 3'd0,
    OP_TICK    = 3'd1,
    OP_RESULT  = 3'd2,
    OP_CANCEL  = 3'd3,
    OP_ESTOP   = 3'd4,
    OP_EMITTED = 3'd5,
    OP_REINIT  = 3'd6
  } opcode_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_VALIDATING = 3'd1,
    PH_RUNNING    = 3'd2,
    PH_STOPPING   = 3'd3,
    PH_COMPLETE   = 3'd4,
    PH_CANCELING  = 3'd5,
    PH_FAULT      = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_ON   = 2'd1,
    ACT_OFF  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    OC_NONE     = 3'd0,
    OC_COMPLETE = 3'd1,
    OC_CANCELED = 3'd2,
    OC_REJECTED = 3'd3,
    OC_FAULT    = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    ACC_OK       = 2'd0,
    ACC_NOT_IDLE = 2'd1,
    ACC_BAD_ARG  = 2'd2
  } accept_t;

  typedef enum logic [1:0] {
    FK_NONE     = 2'd0,
    FK_INTERNAL = 2'd1,
    FK_IO       = 2'd2
  } fault_kind_t;

  typedef enum logic {
    FL_WARNING     = 1'b0,
    FL_RECOVERABLE = 1'b1
  } fault_level_t;

  typedef enum logic [1:0] {
    PK_UNKNOWN = 2'd0,
    PK_OFF     = 2'd1,
    PK_ON      = 2'd2
  } pump_know_t;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [TimeW-1:0] now_ms;
    logic [TagW-1:0]  request_tag;
    logic [DoseW-1:0] dose_ms;
    logic             safety_trip;
    logic             pos_valid;
    logic             pos_fresh;
    logic             pos_stable;
    logic             drum_moving;
    logic [2:0]       drum_position;
    logic [1:0]       done_action;
    logic             done_ok;
  } item_t;

  typedef struct packed {
    phase_t           phase;
    pump_know_t       pump_know;
    logic [TagW-1:0]  active_tag;
    logic [DoseW-1:0] run_length;
    logic [TimeW-1:0] start_time;
    action_t          awaited;
    outcome_t         final_oc;
    fault_kind_t      final_kind;
    fault_level_t     final_level;
    logic             reported;
  } state_t;

  typedef struct packed {
    accept_t      accept_status;
    phase_t       next_phase;
    action_t      pump_command;
    outcome_t     outcome;
    fault_kind_t  fault_kind;
    fault_level_t fault_level;
    logic         event_due;
    pump_know_t   pump_known;
    logic         outcome_pending;
  } result_t;

  localparam state_t StateReset = '{
    phase:       PH_IDLE,
    pump_know:   PK_OFF,
    active_tag:  '0,
    run_length:  '0,
    start_time:  '0,
    awaited:     ACT_NONE,
    final_oc:    OC_NONE,
    final_kind:  FK_NONE,
    final_level: FL_WARNING,
    reported:    1'b0
  };

endpackage

FILE: rtl/tpds_step.sv
// ----------------------------------------------------------------------------
// Sequencer step logic
// Next state and result beat for one registered item and the current state.
// ----------------------------------------------------------------------------
module tpds_step (
  input  tpds_pkg::item_t              item,
  input  tpds_pkg::state_t             cur,
  input  logic [tpds_pkg::DoseW-1:0]   max_dose,
  output tpds_pkg::state_t             nxt,
  output tpds_pkg::result_t            res
);
  import tpds_pkg::*;

  logic [TimeW-1:0] elapsed;
  logic             dose_due;
  logic             bad_arg;
  logic             interlock_bad;

  assign elapsed       = item.now_ms - cur.start_time;
  assign dose_due      = elapsed >= {{(TimeW-DoseW){1'b0}}, cur.run_length};
  assign bad_arg       = (item.request_tag == '0) || (item.dose_ms == '0) ||
                         (item.dose_ms > max_dose);
  assign interlock_bad = !item.pos_valid || !item.pos_fresh || !item.pos_stable ||
                         item.drum_moving || (item.drum_position != 3'd0);

  always_comb begin
    nxt                 = cur;
    res.accept_status   = ACC_OK;
    res.pump_command    = ACT_NONE;
    res.outcome         = OC_NONE;
    res.fault_kind      = FK_NONE;
    res.fault_level     = FL_WARNING;
    res.event_due       = 1'b0;
    case (item.opcode)
      OP_BEGIN: begin
        if (cur.phase != PH_IDLE) begin
          res.accept_status = ACC_NOT_IDLE;
        end else if (bad_arg) begin
          res.accept_status = ACC_BAD_ARG;
        end else begin
          nxt.active_tag  = item.request_tag;
          nxt.run_length  = item.dose_ms;
          nxt.phase       = PH_VALIDATING;
          nxt.start_time  = item.now_ms;
          nxt.reported    = 1'b0;
          nxt.final_oc    = OC_NONE;
          nxt.awaited     = ACT_NONE;
          nxt.final_kind  = FK_NONE;
          nxt.final_level = FL_WARNING;
        end
      end
      OP_TICK: begin
        if (cur.phase == PH_VALIDATING) begin
          if (item.safety_trip) begin
            nxt.phase       = PH_FAULT;
            res.outcome     = OC_FAULT;
            res.fault_kind  = FK_INTERNAL;
            res.fault_level = FL_RECOVERABLE;
            res.event_due   = 1'b1;
          end else if (interlock_bad) begin
            nxt.phase      = PH_FAULT;
            res.outcome    = OC_REJECTED;
            res.event_due  = 1'b1;
          end else begin
            nxt.phase        = PH_RUNNING;
            nxt.start_time   = item.now_ms;
            res.pump_command = ACT_ON;
            nxt.awaited      = ACT_ON;
          end
        end else if (cur.phase == PH_RUNNING && dose_due) begin
          nxt.phase        = PH_STOPPING;
          res.pump_command = ACT_OFF;
          nxt.awaited      = ACT_OFF;
        end
      end
      OP_RESULT: begin
        if (item.done_action == cur.awaited) begin
          nxt.awaited = ACT_NONE;
          if (cur.awaited == ACT_ON) begin
            if (item.done_ok) begin
              nxt.pump_know = PK_ON;
            end else begin
              nxt.pump_know    = PK_UNKNOWN;
              nxt.phase        = PH_STOPPING;
              res.pump_command = ACT_OFF;
              nxt.awaited      = ACT_OFF;
              res.outcome      = OC_FAULT;
              res.fault_kind   = FK_IO;
              res.fault_level  = FL_RECOVERABLE;
              res.event_due    = 1'b1;
            end
          end else if (cur.awaited == ACT_OFF) begin
            nxt.pump_know = item.done_ok ? PK_OFF : PK_UNKNOWN;
            if (cur.phase == PH_STOPPING) begin
              nxt.phase = PH_COMPLETE;
              if (cur.final_oc == OC_NONE) begin
                res.outcome    = OC_COMPLETE;
                res.event_due  = 1'b1;
              end else begin
                res.outcome     = cur.final_oc;
                res.fault_kind  = cur.final_kind;
                res.fault_level = cur.final_level;
                res.event_due   = !cur.reported;
              end
            end else if (cur.phase == PH_CANCELING) begin
              nxt.phase      = PH_COMPLETE;
              res.outcome    = OC_CANCELED;
              res.event_due  = 1'b1;
            end
          end
        end
      end
      OP_CANCEL: begin
        if (item.request_tag == cur.active_tag && cur.phase == PH_RUNNING) begin
          nxt.phase        = PH_CANCELING;
          res.pump_command = ACT_OFF;
          nxt.awaited      = ACT_OFF;
        end
      end
      OP_ESTOP: begin
        if (cur.phase != PH_IDLE && cur.phase != PH_COMPLETE &&
            cur.phase != PH_FAULT) begin
          nxt.phase        = PH_STOPPING;
          res.pump_command = ACT_OFF;
          nxt.awaited      = ACT_OFF;
          res.outcome      = OC_FAULT;
          res.fault_kind   = FK_INTERNAL;
          res.fault_level  = FL_RECOVERABLE;
          res.event_due    = 1'b1;
        end
      end
      OP_EMITTED: begin
        nxt.reported = 1'b1;
      end
      OP_REINIT: begin
        nxt = StateReset;
      end
      default: begin
      end
    endcase
    // A beat that raises an event records its outcome, unless it completes a stop whose outcome is already recorded.
    if (res.event_due && !(item.opcode == OP_RESULT && cur.phase == PH_STOPPING &&
                           cur.final_oc != OC_NONE)) begin
      nxt.final_oc    = res.outcome;
      nxt.final_kind  = res.fault_kind;
      nxt.final_level = res.fault_level;
    end
    res.next_phase      = nxt.phase;
    res.pump_known      = nxt.pump_know;
    res.outcome_pending = !nxt.reported && (nxt.final_oc != OC_NONE);
  end

endmodule

FILE: rtl/timed_pump_dose_sequencer.sv
// ----------------------------------------------------------------------------
// Timed pump dose sequencer
// Safety-interlocked dosing job control, one command beat per cycle when unstalled.
//
//   Channel   Direction  Handshake            Contents
//   in_*      input      in_valid/in_stall    opcode and sensor snapshot
//   out_*     output     out_valid/out_stall  phase, pump command, outcome
//   cfg_*     input      cfg_wr_en            max_dose_ms limit
//
// Each beat is held in an input register and evaluated combinationally against
// the job state; the state and result registers are updated at the same edge.
// A beat passes from the input register to the result register on its way out,
// and one beat is accepted every cycle while the output side is not stalled.
// Reset is synchronous; the job state returns to idle with the pump known off.
// A stalled output holds its beat, and the input register keeps one more beat.
// ----------------------------------------------------------------------------
module timed_pump_dose_sequencer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_opcode,
  input  logic [31:0]                 in_now_ms,
  input  logic [15:0]                 in_request_tag,
  input  logic [19:0]                 in_dose_ms,
  input  logic                        in_safety_trip,
  input  logic                        in_pos_valid,
  input  logic                        in_pos_fresh,
  input  logic                        in_pos_stable,
  input  logic                        in_drum_moving,
  input  logic [2:0]                  in_drum_position,
  input  logic [1:0]                  in_done_action,
  input  logic                        in_done_ok,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_accept_status,
  output logic [2:0]                  out_next_phase,
  output logic [1:0]                  out_pump_command,
  output logic [2:0]                  out_outcome,
  output logic [1:0]                  out_fault_kind,
  output logic                        out_fault_level,
  output logic                        out_event_due,
  output logic [1:0]                  out_pump_known,
  output logic                        out_outcome_pending,
  input  logic                        cfg_wr_en,
  input  logic [tpds_pkg::DoseW-1:0]  cfg_wr_data
);
  import tpds_pkg::*;

  item_t             item_in;
  item_t             item_r;
  logic              item_v_r;
  logic              item_v_nxt;
  state_t            state_r;
  state_t            state_nxt;
  result_t           res_r;
  result_t           res_nxt;
  logic              out_v_r;
  logic              out_v_nxt;
  logic [DoseW-1:0]  max_dose_r;
  logic              advance;
  logic              in_take;

  assign item_in = '{
    opcode:        in_opcode,
    now_ms:        in_now_ms,
    request_tag:   in_request_tag,
    dose_ms:       in_dose_ms,
    safety_trip:   in_safety_trip,
    pos_valid:     in_pos_valid,
    pos_fresh:     in_pos_fresh,
    pos_stable:    in_pos_stable,
    drum_moving:   in_drum_moving,
    drum_position: in_drum_position,
    done_action:   in_done_action,
    done_ok:       in_done_ok
  };

  assign advance    = item_v_r && (!out_v_r || !out_stall);
  assign in_stall   = item_v_r && !advance;
  assign in_take    = in_valid && !in_stall;
  assign item_v_nxt = in_take || (item_v_r && !advance);
  assign out_v_nxt  = advance || (out_v_r && out_stall);

  tpds_step u_step (
    .item     (item_r),
    .cur      (state_r),
    .max_dose (max_dose_r),
    .nxt      (state_nxt),
    .res      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
      state_r    <= StateReset;
      max_dose_r <= MaxDoseReset;
    end else begin
      item_v_r <= item_v_nxt;
      out_v_r  <= out_v_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
      if (cfg_wr_en) begin
        max_dose_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= item_in;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_v_r;
  assign out_accept_status   = res_r.accept_status;
  assign out_next_phase      = res_r.next_phase;
  assign out_pump_command    = res_r.pump_command;
  assign out_outcome         = res_r.outcome;
  assign out_fault_kind      = res_r.fault_kind;
  assign out_fault_level     = res_r.fault_level;
  assign out_event_due       = res_r.event_due;
  assign out_pump_known      = res_r.pump_known;
  assign out_outcome_pending = res_r.outcome_pending;

  a_event_has_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.event_due |-> res_r.outcome != OC_NONE)
    else $error("terminal event beat carries no outcome");

  a_pump_on_runs: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.pump_command == ACT_ON |-> res_r.next_phase == PH_RUNNING)
    else $error("pump-on command outside the running phase");

  a_idle_awaits_none: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == PH_IDLE |-> state_r.awaited == ACT_NONE)
    else $error("idle phase still awaits a pump action");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(advance) && $past(rst_n) |-> $stable(state_r))
    else $error("job state changed without a beat");

endmodule
